>>> rtl/core/jrd_pkg.sv
package jrd_pkg;

	// field and datapath widths
	localparam int IN_W     = 16;
	localparam int DZ_W     = 15;
	localparam int R8_W     = 24;
	localparam int SQ_STEPS = R8_W;
	localparam int SC_W     = 23;
	localparam int NUM_W    = 39;
	localparam int DEN_W    = 24;
	localparam int QUO_W    = 25;

	// constants of the mapping
	localparam logic [DZ_W-1:0] FULL_SCALE = 15'd32767;
	localparam logic [DZ_W-1:0] DZ_MAX     = 15'd32766;
	localparam logic [DZ_W-1:0] DZ_RESET   = 15'd9830;

	// register word select (paddr bit 2)
	localparam logic REG_DEADZONE = 1'b0;

	// per-sample data that rides along the arithmetic units
	typedef struct packed {
		logic            sign_x;
		logic            sign_y;
		logic [IN_W-1:0] mag_x;
		logic [IN_W-1:0] mag_y;
		logic [DZ_W-1:0] dz;
		logic            in_dz;
		logic [R8_W-1:0] r8;
	} side_t;

endpackage

>>> rtl/core/joystick_radial_deadzone.sv
// Circular dead zone for a thumbstick sample.
// Input channel: stick_x, stick_y (signed 16 bit) qualified by in_valid;
// a request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_x, out_y (signed 16 bit) and in_deadzone, qualified
// by out_valid; the receiver holds a request back with out_stall.
// Each sample gives exactly one result, in order, after the squares and
// dead zone test, the bit-per-stage square root, a register and the
// rescale divider, a register and the direction dividers and the output
// register. One sample is taken per cycle unless a result is stalled.
// While a result waits under out_stall the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// Register deadzone_radius (15 bit) sits at byte address 0 of the APB
// port and should only be written while the block is empty. A value of
// 32767 behaves as 32766.
// Reset clears all valid bits and loads deadzone_radius with 9830.
module joystick_radial_deadzone (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [15:0]         stick_x,
	input  logic signed [15:0]         stick_y,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic                       in_deadzone,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import jrd_pkg::*;

	logic [DZ_W-1:0]  dz_q;
	logic [DZ_W-1:0]  dz_eff;
	logic             adv;

	logic             fr_valid;
	logic [31:0]      fr_sum;
	side_t            fr_side;
	logic             sq_valid;
	logic [R8_W-1:0]  sq_root;
	side_t            sq_side;

	logic             valid_s1;
	logic [NUM_W-1:0] num_s1;
	logic [DEN_W-1:0] den_s1;
	side_t            side_s1;

	logic             sc_valid;
	logic [QUO_W-1:0] sc_quo;
	side_t            sc_side;

	logic             valid_s2;
	logic [NUM_W-1:0] prod_x_s2, prod_y_s2;
	side_t            side_s2;

	logic             dx_valid, dy_valid;
	logic [QUO_W-1:0] dx_quo, dy_quo;
	side_t            dx_side, dy_side;

	logic             valid_s3;
	logic [15:0]      out_x_s3, out_y_s3;
	logic             in_dz_s3;

	logic [R8_W-1:0]  rc8;
	logic [SC_W-1:0]  dz8;
	logic [SC_W-1:0]  diff;
	logic [SC_W-1:0]  sc8;
	side_t            side_c;
	logic [15:0]      ax_x, ax_y;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEADZONE) ? 32'(dz_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEADZONE) begin
			dz_q <= pwdata[DZ_W-1:0];
		end
	end

	assign dz_eff = (dz_q > DZ_MAX) ? DZ_MAX : dz_q;

	// whole pipeline holds while the output request is stalled
	assign adv      = !(valid_s3 && out_stall);
	assign in_stall = !adv;

	jrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.stick_x  (stick_x),
		.stick_y  (stick_y),
		.dz       (dz_eff),
		.valid_o  (fr_valid),
		.sum_o    (fr_sum),
		.side_o   (fr_side)
	);

	jrd_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (fr_valid),
		.sum_i   (fr_sum),
		.side_i  (fr_side),
		.valid_o (sq_valid),
		.root_o  (sq_root),
		.side_o  (sq_side)
	);

	// clip radius and form the rescale numerator (times 32767 by shift)
	always_comb begin
		rc8 = (sq_root > R8_W'({FULL_SCALE, 8'h00})) ? R8_W'({FULL_SCALE, 8'h00}) : sq_root;
		dz8 = {sq_side.dz, 8'h00};
		diff = (rc8 > R8_W'(dz8)) ? SC_W'(rc8 - R8_W'(dz8)) : '0;
		side_c    = sq_side;
		side_c.r8 = sq_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sq_valid;
			valid_s2 <= sc_valid;
			valid_s3 <= dx_valid && dy_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= NUM_W'({diff, 15'h0000}) - NUM_W'(diff);
			den_s1  <= DEN_W'(FULL_SCALE - sq_side.dz);
			side_s1 <= side_c;
		end
	end

	jrd_div u_div_sc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (valid_s1),
		.num_i   (num_s1),
		.den_i   (den_s1),
		.side_i  (side_s1),
		.valid_o (sc_valid),
		.quo_o   (sc_quo),
		.side_o  (sc_side)
	);

	// scaled magnitude times each axis magnitude
	assign sc8 = sc_quo[SC_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s2 <= NUM_W'(sc_side.mag_x * sc8);
			prod_y_s2 <= NUM_W'(sc_side.mag_y * sc8);
			side_s2   <= sc_side;
		end
	end

	jrd_div u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (valid_s2),
		.num_i   (prod_x_s2),
		.den_i   (side_s2.r8),
		.side_i  (side_s2),
		.valid_o (dx_valid),
		.quo_o   (dx_quo),
		.side_o  (dx_side)
	);

	jrd_div u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (valid_s2),
		.num_i   (prod_y_s2),
		.den_i   (side_s2.r8),
		.side_i  (side_s2),
		.valid_o (dy_valid),
		.quo_o   (dy_quo),
		.side_o  (dy_side)
	);

	// drop the low 8 bits of the Q0 quotient, saturate and restore the sign
	always_comb begin
		ax_x = (dx_quo[QUO_W-1:8] > (QUO_W-8)'(FULL_SCALE)) ? 16'(FULL_SCALE)
			: 16'(dx_quo[QUO_W-1:8]);
		ax_y = (dy_quo[QUO_W-1:8] > (QUO_W-8)'(FULL_SCALE)) ? 16'(FULL_SCALE)
			: 16'(dy_quo[QUO_W-1:8]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dy_side.in_dz) begin
				out_x_s3 <= '0;
				out_y_s3 <= '0;
			end else begin
				out_x_s3 <= dx_side.sign_x ? 16'(~ax_x + 1'b1) : ax_x;
				out_y_s3 <= dy_side.sign_y ? 16'(~ax_y + 1'b1) : ax_y;
			end
			in_dz_s3 <= dy_side.in_dz;
		end
	end

	assign out_valid   = valid_s3;
	assign out_x       = out_x_s3;
	assign out_y       = out_y_s3;
	assign in_deadzone = in_dz_s3;
endmodule

>>> rtl/core/jrd_front.sv
module jrd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [jrd_pkg::IN_W-1:0]  stick_x,
	input  logic [jrd_pkg::IN_W-1:0]  stick_y,
	input  logic [jrd_pkg::DZ_W-1:0]  dz,
	output logic                      valid_o,
	output logic [31:0]               sum_o,
	output jrd_pkg::side_t            side_o
);
	import jrd_pkg::*;

	logic            valid_s1, valid_s2, valid_s3;
	side_t           side_s1, side_s2, side_s3;
	logic [30:0]     sq_x_s2, sq_y_s2;
	logic [29:0]     dzsq_s2;
	logic [31:0]     sum_s3;
	logic [31:0]     sum_c;
	side_t           side_c;
	side_t           side_dz_c;

	// sign and magnitude of the raw sample
	always_comb begin
		side_c        = '0;
		side_c.sign_x = stick_x[IN_W-1];
		side_c.sign_y = stick_y[IN_W-1];
		side_c.mag_x  = stick_x[IN_W-1] ? IN_W'(~stick_x + 1'b1) : stick_x;
		side_c.mag_y  = stick_y[IN_W-1] ? IN_W'(~stick_y + 1'b1) : stick_y;
		side_c.dz     = dz;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign sum_c = 32'(sq_x_s2) + 32'(sq_y_s2);

	// dead zone flag joins the side data
	always_comb begin
		side_dz_c       = side_s2;
		side_dz_c.in_dz = (sum_c <= 32'(dzsq_s2));
	end

	// stage 1 input, stage 2 squares, stage 3 sum and dead zone test
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1        <= side_c;
			sq_x_s2        <= 31'(side_s1.mag_x * side_s1.mag_x);
			sq_y_s2        <= 31'(side_s1.mag_y * side_s1.mag_y);
			dzsq_s2        <= 30'(side_s1.dz * side_s1.dz);
			side_s2        <= side_s1;
			sum_s3         <= sum_c;
			side_s3        <= side_dz_c;
		end
	end

	assign valid_o = valid_s3;
	assign sum_o   = sum_s3;
	assign side_o  = side_s3;
endmodule

>>> rtl/core/jrd_isqrt.sv
module jrd_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      valid_i,
	input  logic [31:0]               sum_i,
	input  jrd_pkg::side_t            side_i,
	output logic                      valid_o,
	output logic [jrd_pkg::R8_W-1:0]  root_o,
	output jrd_pkg::side_t            side_o
);
	import jrd_pkg::*;

	localparam int V_W   = 2 * SQ_STEPS;
	localparam int REM_W = R8_W + 1;

	logic              vld  [0:SQ_STEPS];
	logic [V_W-1:0]    rad  [0:SQ_STEPS];
	logic [REM_W-1:0]  rem  [0:SQ_STEPS];
	logic [R8_W-1:0]   root [0:SQ_STEPS];
	side_t             side [0:SQ_STEPS];

	// radicand is the sum in Q16 so the root comes out in Q8
	assign vld[0]  = valid_i;
	assign rad[0]  = V_W'({sum_i, 16'h0000});
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign side[0] = side_i;

	// one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [REM_W+1:0] part;
		logic [REM_W+1:0] trial;
		logic             ge;

		assign part  = {rem[k], rad[k][V_W-1 -: 2]};
		assign trial = (REM_W+2)'({root[k], 2'b01});
		assign ge    = (part >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (adv) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad[k+1]  <= {rad[k][V_W-3:0], 2'b00};
				rem[k+1]  <= ge ? REM_W'(part - trial) : REM_W'(part);
				root[k+1] <= {root[k][R8_W-2:0], ge};
				side[k+1] <= side[k];
			end
		end
	end

	assign valid_o = vld[SQ_STEPS];
	assign root_o  = root[SQ_STEPS];
	assign side_o  = side[SQ_STEPS];
endmodule

>>> rtl/core/jrd_div.sv
module jrd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       valid_i,
	input  logic [jrd_pkg::NUM_W-1:0]  num_i,
	input  logic [jrd_pkg::DEN_W-1:0]  den_i,
	input  jrd_pkg::side_t             side_i,
	output logic                       valid_o,
	output logic [jrd_pkg::QUO_W-1:0]  quo_o,
	output jrd_pkg::side_t             side_o
);
	import jrd_pkg::*;

	logic              vld  [0:QUO_W];
	logic [DEN_W-1:0]  rem  [0:QUO_W];
	logic [QUO_W-1:0]  low  [0:QUO_W];
	logic [QUO_W-1:0]  quo  [0:QUO_W];
	logic [DEN_W-1:0]  den  [0:QUO_W];
	side_t             side [0:QUO_W];

	// upper numerator bits sit below the divisor by construction
	assign vld[0]  = valid_i;
	assign rem[0]  = DEN_W'(num_i[NUM_W-1:QUO_W]);
	assign low[0]  = num_i[QUO_W-1:0];
	assign quo[0]  = '0;
	assign den[0]  = den_i;
	assign side[0] = side_i;

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] part;
		logic           ge;

		assign part = {rem[k], low[k][QUO_W-1]};
		assign ge   = (part >= {1'b0, den[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (adv) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem[k+1]  <= ge ? DEN_W'(part - {1'b0, den[k]}) : DEN_W'(part);
				low[k+1]  <= {low[k][QUO_W-2:0], 1'b0};
				quo[k+1]  <= {quo[k][QUO_W-2:0], ge};
				den[k+1]  <= den[k];
				side[k+1] <= side[k];
			end
		end
	end

	assign valid_o = vld[QUO_W];
	assign quo_o   = quo[QUO_W];
	assign side_o  = side[QUO_W];
endmodule
